[rtl/lfu_pkg.sv]
// shared constants and payload types for the lfu replacement policy
package lfu_pkg;

    // default geometry
    localparam int ENTRIES_DEF    = 64;
    localparam int COUNT_BITS_DEF = 16;
    localparam int STAMP_BITS_DEF = 32;

    // fixed field widths of the request and result channels
    localparam int MODE_W  = 2;
    localparam int SLOT_W  = 6;
    localparam int MINCNT_W = 16;

    // request modes
    localparam logic [MODE_W-1:0] MODE_TOUCH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SLOT_W-1:0] slot;
    } t_req;

    typedef struct packed {
        logic                victim_valid;
        logic [SLOT_W-1:0]   victim_slot;
        logic [MINCNT_W-1:0] min_count;
    } t_res;

endpackage

[rtl/lfu_stream_if.sv]
// valid/ready channel carrying one request or result payload
interface lfu_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/lfu_replacement_policy.sv]
// lfu replacement policy top level: launch stage, row of slot cells, result port
//
// Requests arrive on i_req (mode, slot) and each produces one result on
// o_res: the least frequently used live slot, the oldest on equal counts,
// and its count. Slot state lives in a row of ENTRIES cells. A request
// travels the row as a wave, one cell per cycle while the row advances;
// each cell applies the request to its slot as the wave passes and then
// offers itself as the victim, so the result leaves the last cell after
// the whole row is seen, having passed the launch register and then every
// cell register. A new request enters every cycle unless the row holds,
// so several requests travel the row at once, in order.
// The last cell's register is the result register. While a result waits
// for o_res.ready the whole row holds and i_req.ready is low; bubbles in
// the row hold where they are.
// Reset (synchronous, active low) clears all valid bits, the stamp counter
// and the row, leaving an empty store; results report no victim, count 0.
module lfu_replacement_policy import lfu_pkg::*; #(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int STAMP_BITS = STAMP_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lfu_stream_if.sink   i_req,
    lfu_stream_if.source o_res
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int WAVE_W = 1 + MODE_W + 1 + IDX_W + 2 * STAMP_BITS
                            + 1 + IDX_W + COUNT_BITS + STAMP_BITS;

    typedef struct packed {
        logic                  vld;
        logic [MODE_W-1:0]     mode;
        logic                  hit;
        logic [IDX_W-1:0]      idx;
        logic [STAMP_BITS-1:0] fresh;
        logic [STAMP_BITS-1:0] ref_ctr;
        logic                  found;
        logic [IDX_W-1:0]      best_idx;
        logic [COUNT_BITS-1:0] best_cnt;
        logic [STAMP_BITS-1:0] best_age;
    } t_wave;

    logic [WAVE_W-1:0] wave [ENTRIES+1];
    t_wave             w_first;
    t_wave             w_last;
    logic              en;
    logic              acc;
    t_req              req;

    // the row advances unless a finished result is stalled
    assign w_first     = wave[0];
    assign w_last      = wave[ENTRIES];
    assign en          = !w_last.vld || o_res.ready;
    assign i_req.ready = en;
    assign acc         = i_req.valid && en;
    assign req         = i_req.payload;

    lfu_head #(
        .ENTRIES    (ENTRIES),
        .COUNT_BITS (COUNT_BITS),
        .STAMP_BITS (STAMP_BITS)
    ) u_head (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_acc   (acc),
        .i_mode  (req.mode),
        .i_slot  (req.slot),
        .o_wave  (wave[0])
    );

    // row of slot cells
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lfu_cell #(
            .ENTRIES    (ENTRIES),
            .COUNT_BITS (COUNT_BITS),
            .STAMP_BITS (STAMP_BITS),
            .MY_IDX     (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_wave  (wave[g]),
            .o_wave  (wave[g+1])
        );
    end

    // result formatting
    assign o_res.valid                = w_last.vld;
    assign o_res.payload.victim_valid = w_last.found;
    assign o_res.payload.victim_slot  = w_last.found ? SLOT_W'(w_last.best_idx) : '0;
    assign o_res.payload.min_count    = w_last.found ? MINCNT_W'(w_last.best_cnt) : '0;

    // a stalled result must block new requests
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |-> !i_req.ready)
        else $error("request accepted while result stalled");

    // an accepted request enters the row on the next cycle
    a_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> w_first.vld)
        else $error("accepted request not launched");

    // a live victim always has a nonzero use count
    a_victim_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last.vld && w_last.found |-> w_last.best_cnt != '0)
        else $error("victim with zero use count");

endmodule

[rtl/lfu_head.sv]
// chain entry: stamp counter, shadow valid bits and wave launch register
module lfu_head import lfu_pkg::*; #(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int STAMP_BITS = STAMP_BITS_DEF,
    localparam int IDX_W     = $clog2(ENTRIES),
    localparam int WAVE_W    = 1 + MODE_W + 1 + IDX_W + 2 * STAMP_BITS
                               + 1 + IDX_W + COUNT_BITS + STAMP_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_acc,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [SLOT_W-1:0] i_slot,
    output logic [WAVE_W-1:0] o_wave
);

    typedef struct packed {
        logic                  vld;
        logic [MODE_W-1:0]     mode;
        logic                  hit;
        logic [IDX_W-1:0]      idx;
        logic [STAMP_BITS-1:0] fresh;
        logic [STAMP_BITS-1:0] ref_ctr;
        logic                  found;
        logic [IDX_W-1:0]      best_idx;
        logic [COUNT_BITS-1:0] best_cnt;
        logic [STAMP_BITS-1:0] best_age;
    } t_wave;

    logic [ENTRIES-1:0]    r_valid, n_valid;
    logic [STAMP_BITS-1:0] r_ctr, n_ctr;
    t_wave                 r_wave, n_wave;
    logic                  hit;
    logic [IDX_W-1:0]      idx;
    logic                  do_stamp;

    // slot decode; indexes beyond the slot range are ignored
    assign hit = ({{(32 - SLOT_W){1'b0}}, i_slot} < 32'(ENTRIES));
    assign idx = IDX_W'(i_slot);

    // a touch takes a stamp only when the slot is live, insert always does
    always_comb begin
        do_stamp = 1'b0;
        n_valid  = r_valid;
        if (hit) begin
            case (i_mode)
                MODE_TOUCH:  do_stamp = r_valid[idx];
                MODE_INSERT: begin
                    do_stamp     = 1'b1;
                    n_valid[idx] = 1'b1;
                end
                MODE_REMOVE: n_valid[idx] = 1'b0;
                default:     ;
            endcase
        end
        n_ctr = r_ctr + STAMP_BITS'(do_stamp);
    end

    // launch the wave with the post-request counter as age reference
    always_comb begin
        n_wave          = '0;
        n_wave.vld      = i_acc;
        n_wave.mode     = i_mode;
        n_wave.hit      = hit;
        n_wave.idx      = idx;
        n_wave.fresh    = r_ctr;
        n_wave.ref_ctr  = n_ctr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_ctr      <= '0;
            r_wave.vld <= 1'b0;
        end else if (i_en) begin
            r_wave <= n_wave;
            if (i_acc) begin
                r_valid <= n_valid;
                r_ctr   <= n_ctr;
            end
        end
    end

    assign o_wave = r_wave;

endmodule

[rtl/lfu_cell.sv]
// one slot: applies the passing request and folds itself into the victim search
module lfu_cell import lfu_pkg::*; #(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int STAMP_BITS = STAMP_BITS_DEF,
    parameter int MY_IDX     = 0,
    localparam int IDX_W     = $clog2(ENTRIES),
    localparam int WAVE_W    = 1 + MODE_W + 1 + IDX_W + 2 * STAMP_BITS
                               + 1 + IDX_W + COUNT_BITS + STAMP_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [WAVE_W-1:0] i_wave,
    output logic [WAVE_W-1:0] o_wave
);

    typedef struct packed {
        logic                  vld;
        logic [MODE_W-1:0]     mode;
        logic                  hit;
        logic [IDX_W-1:0]      idx;
        logic [STAMP_BITS-1:0] fresh;
        logic [STAMP_BITS-1:0] ref_ctr;
        logic                  found;
        logic [IDX_W-1:0]      best_idx;
        logic [COUNT_BITS-1:0] best_cnt;
        logic [STAMP_BITS-1:0] best_age;
    } t_wave;

    t_wave                 w_in;
    t_wave                 r_wave, n_wave;
    logic                  r_valid, n_valid;
    logic [COUNT_BITS-1:0] r_cnt, n_cnt;
    logic [STAMP_BITS-1:0] r_stamp, n_stamp;
    logic                  sel;
    logic [STAMP_BITS-1:0] age;
    logic                  take;

    assign w_in = i_wave;
    assign sel  = w_in.vld && w_in.hit && (w_in.idx == IDX_W'(MY_IDX));

    // slot update for a request addressed here
    always_comb begin
        n_valid = r_valid;
        n_cnt   = r_cnt;
        n_stamp = r_stamp;
        if (sel) begin
            case (w_in.mode)
                MODE_TOUCH: begin
                    if (r_valid) begin
                        if (r_cnt != '1) begin
                            n_cnt = r_cnt + COUNT_BITS'(1);
                        end
                        n_stamp = w_in.fresh;
                    end
                end
                MODE_INSERT: begin
                    n_valid = 1'b1;
                    n_cnt   = COUNT_BITS'(1);
                    n_stamp = w_in.fresh;
                end
                MODE_REMOVE: n_valid = 1'b0;
                default:     ;
            endcase
        end
    end

    // lower count wins, then older stamp; earlier cells keep exact ties
    assign age  = w_in.ref_ctr - n_stamp;
    assign take = n_valid && (!w_in.found || (n_cnt < w_in.best_cnt) ||
                  ((n_cnt == w_in.best_cnt) && (age > w_in.best_age)));

    always_comb begin
        n_wave = w_in;
        if (take) begin
            n_wave.found    = 1'b1;
            n_wave.best_idx = IDX_W'(MY_IDX);
            n_wave.best_cnt = n_cnt;
            n_wave.best_age = age;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_wave.vld <= 1'b0;
        end else if (i_en) begin
            r_wave  <= n_wave;
            r_valid <= n_valid;
            r_cnt   <= n_cnt;
            r_stamp <= n_stamp;
        end
    end

    assign o_wave = r_wave;

endmodule
